/* rtl/psdf_pkg.sv */
// Shared constants, codes and types of the plot segment discontinuity filter.
`default_nettype none

package psdf_pkg;

   localparam int unsigned COORD_W    = 32;
   localparam int unsigned FRAC_BITS  = 16;
   localparam int unsigned DIFF_W     = COORD_W + 1;
   localparam int unsigned LIMIT_W    = 32;
   localparam int unsigned SPLIT_BITS = 16;
   localparam int unsigned HI_W       = DIFF_W - SPLIT_BITS;
   localparam int unsigned LO_PROD_W  = LIMIT_W + SPLIT_BITS;
   localparam int unsigned HI_PROD_W  = LIMIT_W + HI_W;
   localparam int unsigned PROD_W     = LIMIT_W + DIFF_W;

   localparam int unsigned MODE_W     = 2;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 32;

   localparam int unsigned Q_DEPTH    = 4;
   localparam int unsigned Q_PTR_W    = 2;
   localparam int unsigned Q_CNT_W    = 3;

   localparam logic [MODE_W-1:0] MODE_CARTESIAN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POLAR     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POINTS    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PLOT_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_LIMIT = 1'd1;

   localparam logic [LIMIT_W-1:0] SLOPE_LIMIT_RESET = 32'd655360;

   // One classified point as handed from the front end to the back end.
   typedef struct packed {
      logic [COORD_W-1:0] cur_x;
      logic [COORD_W-1:0] cur_y;
      logic [COORD_W-1:0] prev_x;
      logic [COORD_W-1:0] prev_y;
      logic               cur_ok;
      logic               start;
      logic               both_ok;
      logic               neg;
      logic               flat;
   } psdf_entry_type;

   typedef struct packed {
      logic           push;
      psdf_entry_type entry;
   } psdf_push_type;

   typedef struct packed {
      logic           valid;
      logic           full;
      psdf_entry_type head;
   } psdf_qstat_type;

endpackage

`default_nettype wire

/* rtl/psdf_front.sv */
// Front end: accepts points, keeps the previous point and classifies each segment's slope.
`default_nettype none

module psdf_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic signed [psdf_pkg::COORD_W-1:0] req_px,
   input  wire logic signed [psdf_pkg::COORD_W-1:0] req_py,
   input  wire logic                             req_py_ok,
   input  wire logic                             req_series_start,
   input  wire logic [psdf_pkg::LIMIT_W-1:0]     slope_limit,
   input  wire logic                             q_full,
   output psdf_pkg::psdf_push_type               push
);

   typedef struct packed {
      logic [psdf_pkg::COORD_W-1:0] cur_x;
      logic [psdf_pkg::COORD_W-1:0] cur_y;
      logic [psdf_pkg::COORD_W-1:0] prev_x;
      logic [psdf_pkg::COORD_W-1:0] prev_y;
      logic                         cur_ok;
      logic                         start;
      logic                         both_ok;
   } carry_type;

   logic [psdf_pkg::COORD_W-1:0] prev_x_ff;
   logic [psdf_pkg::COORD_W-1:0] prev_y_ff;
   logic                         prev_ok_ff;
   logic                         have_prev_ff;

   logic                                s1_v_ff;
   carry_type                           s1_c_ff;
   carry_type                           s1_c_in;
   logic signed [psdf_pkg::DIFF_W-1:0]  s1_dx_ff;
   logic signed [psdf_pkg::DIFF_W-1:0]  s1_dy_ff;
   logic signed [psdf_pkg::DIFF_W-1:0]  s1_dx_in;
   logic signed [psdf_pkg::DIFF_W-1:0]  s1_dy_in;

   logic                           s2_v_ff;
   carry_type                      s2_c_ff;
   logic [psdf_pkg::DIFF_W-1:0]    s2_adx_ff;
   logic [psdf_pkg::DIFF_W-1:0]    s2_ady_ff;
   logic                           s2_neg_ff;
   logic [psdf_pkg::DIFF_W-1:0]    s2_adx_in;
   logic [psdf_pkg::DIFF_W-1:0]    s2_ady_in;
   logic                           s2_neg_in;

   logic                           s3_v_ff;
   carry_type                      s3_c_ff;
   logic                           s3_neg_ff;
   logic                           s3_adx_nz_ff;
   logic [psdf_pkg::DIFF_W-1:0]    s3_ady_ff;
   logic [psdf_pkg::LO_PROD_W-1:0] s3_pp_lo_ff;
   logic [psdf_pkg::HI_PROD_W-1:0] s3_pp_hi_ff;
   logic [psdf_pkg::LO_PROD_W-1:0] s3_pp_lo_in;
   logic [psdf_pkg::HI_PROD_W-1:0] s3_pp_hi_in;

   logic [psdf_pkg::PROD_W-1:0]    prod;
   logic [psdf_pkg::PROD_W-1:0]    rise;
   logic                           flat;

   logic rdy1;
   logic rdy2;
   logic rdy3;
   logic accept;

   // Each stage moves on when it is empty or the stage after it moves.
   assign rdy3      = !s3_v_ff || !q_full;
   assign rdy2      = !s2_v_ff || rdy3;
   assign rdy1      = !s1_v_ff || rdy2;
   assign req_ready = rdy1;
   assign accept    = req_valid && rdy1;

   always_comb begin
      s1_c_in.cur_x   = req_px;
      s1_c_in.cur_y   = req_py;
      s1_c_in.prev_x  = prev_x_ff;
      s1_c_in.prev_y  = prev_y_ff;
      s1_c_in.cur_ok  = req_py_ok;
      s1_c_in.start   = req_series_start || !have_prev_ff;
      s1_c_in.both_ok = req_py_ok && prev_ok_ff;
      s1_dx_in = {req_px[psdf_pkg::COORD_W-1], req_px}
               - {prev_x_ff[psdf_pkg::COORD_W-1], prev_x_ff};
      s1_dy_in = {req_py[psdf_pkg::COORD_W-1], req_py}
               - {prev_y_ff[psdf_pkg::COORD_W-1], prev_y_ff};
   end

   always_comb begin
      s2_adx_in = s1_dx_ff[psdf_pkg::DIFF_W-1] ? -s1_dx_ff : s1_dx_ff;
      s2_ady_in = s1_dy_ff[psdf_pkg::DIFF_W-1] ? -s1_dy_ff : s1_dy_ff;
      s2_neg_in = s1_c_ff.both_ok &&
                  ((s1_dy_ff[psdf_pkg::DIFF_W-1] && !s1_dx_ff[psdf_pkg::DIFF_W-1]) ||
                   (!s1_dy_ff[psdf_pkg::DIFF_W-1] && (s1_dy_ff != '0) &&
                    s1_dx_ff[psdf_pkg::DIFF_W-1]));
   end

   // The limit times |dx| product is split into two narrower partial products.
   always_comb begin
      s3_pp_lo_in = psdf_pkg::LO_PROD_W'(slope_limit)
                  * psdf_pkg::LO_PROD_W'(s2_adx_ff[psdf_pkg::SPLIT_BITS-1:0]);
      s3_pp_hi_in = psdf_pkg::HI_PROD_W'(slope_limit)
                  * psdf_pkg::HI_PROD_W'(s2_adx_ff[psdf_pkg::DIFF_W-1:psdf_pkg::SPLIT_BITS]);
   end

   always_comb begin
      prod = psdf_pkg::PROD_W'(s3_pp_lo_ff)
           + (psdf_pkg::PROD_W'(s3_pp_hi_ff) << psdf_pkg::SPLIT_BITS);
      rise = psdf_pkg::PROD_W'(s3_ady_ff) << psdf_pkg::FRAC_BITS;
      flat = s3_adx_nz_ff && (rise <= prod);
      push.push          = s3_v_ff && !q_full;
      push.entry.cur_x   = s3_c_ff.cur_x;
      push.entry.cur_y   = s3_c_ff.cur_y;
      push.entry.prev_x  = s3_c_ff.prev_x;
      push.entry.prev_y  = s3_c_ff.prev_y;
      push.entry.cur_ok  = s3_c_ff.cur_ok;
      push.entry.start   = s3_c_ff.start;
      push.entry.both_ok = s3_c_ff.both_ok;
      push.entry.neg     = s3_neg_ff;
      push.entry.flat    = flat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_ok_ff   <= 1'b0;
         have_prev_ff <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
      end else begin
         if (accept) begin
            prev_x_ff    <= req_px;
            prev_y_ff    <= req_py;
            prev_ok_ff   <= req_py_ok;
            have_prev_ff <= 1'b1;
         end
         if (rdy1) begin
            s1_v_ff <= req_valid;
         end
         if (rdy2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (rdy3) begin
            s3_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_c_ff  <= s1_c_in;
         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
      end
      if (rdy2 && s1_v_ff) begin
         s2_c_ff   <= s1_c_ff;
         s2_adx_ff <= s2_adx_in;
         s2_ady_ff <= s2_ady_in;
         s2_neg_ff <= s2_neg_in;
      end
      if (rdy3 && s2_v_ff) begin
         s3_c_ff      <= s2_c_ff;
         s3_neg_ff    <= s2_neg_ff;
         s3_adx_nz_ff <= (s2_adx_ff != '0);
         s3_ady_ff    <= s2_ady_ff;
         s3_pp_lo_ff  <= s3_pp_lo_in;
         s3_pp_hi_ff  <= s3_pp_hi_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/psdf_queue.sv */
// Short first-in first-out queue of classified points between front and back end.
`default_nettype none

module psdf_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire psdf_pkg::psdf_push_type  push,
   input  wire logic                     pop,
   output psdf_pkg::psdf_qstat_type      stat
);

   psdf_pkg::psdf_entry_type        mem_ff [psdf_pkg::Q_DEPTH];
   logic [psdf_pkg::Q_PTR_W-1:0]    wr_ptr_ff;
   logic [psdf_pkg::Q_PTR_W-1:0]    rd_ptr_ff;
   logic [psdf_pkg::Q_CNT_W-1:0]    count_ff;
   logic                            do_push;
   logic                            do_pop;

   assign do_push = push.push && (count_ff != psdf_pkg::Q_CNT_W'(psdf_pkg::Q_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      stat.valid = (count_ff != '0);
      stat.full  = (count_ff == psdf_pkg::Q_CNT_W'(psdf_pkg::Q_DEPTH));
      stat.head  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/psdf_back.sv */
// Back end: steep-run state, segment and bridge generation, and the result register.
`default_nettype none

module psdf_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [psdf_pkg::MODE_W-1:0]       plot_mode,
   input  wire psdf_pkg::psdf_qstat_type          qstat,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [psdf_pkg::COORD_W-1:0]    rsp_ax,
   output logic signed [psdf_pkg::COORD_W-1:0]    rsp_ay,
   output logic signed [psdf_pkg::COORD_W-1:0]    rsp_bx,
   output logic signed [psdf_pkg::COORD_W-1:0]    rsp_by,
   output logic                                   rsp_is_point,
   output logic                                   rsp_last_of_item
);

   psdf_pkg::psdf_entry_type e;

   logic [psdf_pkg::COORD_W-1:0] skip_x_ff, skip_x_in;
   logic [psdf_pkg::COORD_W-1:0] skip_y_ff, skip_y_in;
   logic skipped_ff, skipped_in;
   logic bridge_done_ff, bridge_done_in;
   logic prev_neg_ff, prev_neg_in;
   logic phase_ff, phase_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [psdf_pkg::COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [psdf_pkg::COORD_W-1:0] ax_in, ay_in, bx_in, by_in;
   logic is_point_ff, is_point_in;
   logic last_ff, last_in;

   logic emit_seg, emit_bridge, emit_pt;
   logic two, any, load_ok, out_load;

   assign e = qstat.head;

   // Next steep-run state for the point at the head of the queue.
   always_comb begin
      skip_x_in      = skip_x_ff;
      skip_y_in      = skip_y_ff;
      skipped_in     = skipped_ff;
      bridge_done_in = bridge_done_ff;
      prev_neg_in    = prev_neg_ff;
      emit_seg       = 1'b0;
      emit_bridge    = 1'b0;
      emit_pt        = 1'b0;
      priority if (plot_mode == psdf_pkg::MODE_POINTS) begin
         emit_pt = e.cur_ok;
      end else if (e.start) begin
         skipped_in     = 1'b0;
         bridge_done_in = 1'b0;
         prev_neg_in    = 1'b0;
         skip_x_in      = e.cur_x;
         skip_y_in      = e.cur_y;
      end else if (e.both_ok) begin
         priority if (e.flat || (plot_mode == psdf_pkg::MODE_POLAR)) begin
            emit_seg       = 1'b1;
            skipped_in     = 1'b0;
            bridge_done_in = 1'b0;
         end else if (skipped_ff && (prev_neg_ff == e.neg)) begin
            // Second steep segment of the same sign: draw it, bridge once per run.
            emit_seg = 1'b1;
            if (!bridge_done_ff) begin
               emit_bridge    = 1'b1;
               bridge_done_in = 1'b1;
            end
            skipped_in = 1'b1;
         end else begin
            skipped_in     = 1'b1;
            bridge_done_in = 1'b0;
            skip_x_in      = e.prev_x;
            skip_y_in      = e.prev_y;
         end
         prev_neg_in = e.neg;
      end else begin
         skipped_in     = 1'b0;
         bridge_done_in = 1'b0;
         prev_neg_in    = e.neg;
      end
   end

   // A point with a segment and a bridge takes two beats; the state moves on the last.
   always_comb begin
      two      = emit_seg && emit_bridge;
      any      = emit_seg || emit_pt;
      load_ok  = !rsp_valid_ff || rsp_ready;
      out_load = qstat.valid && any && load_ok;
      pop      = qstat.valid && (!any || (load_ok && (!two || phase_ff)));
      phase_in = (out_load && two) ? !phase_ff : phase_ff;

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      priority if (emit_pt) begin
         ax_in       = e.cur_x;
         ay_in       = e.cur_y;
         bx_in       = '0;
         by_in       = '0;
         is_point_in = 1'b1;
         last_in     = 1'b1;
      end else if (phase_ff) begin
         ax_in       = skip_x_ff;
         ay_in       = skip_y_ff;
         bx_in       = e.prev_x;
         by_in       = e.prev_y;
         is_point_in = 1'b0;
         last_in     = 1'b1;
      end else begin
         ax_in       = e.prev_x;
         ay_in       = e.prev_y;
         bx_in       = e.cur_x;
         by_in       = e.cur_y;
         is_point_in = 1'b0;
         last_in     = !two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_x_ff      <= '0;
         skip_y_ff      <= '0;
         skipped_ff     <= 1'b0;
         bridge_done_ff <= 1'b0;
         prev_neg_ff    <= 1'b0;
         phase_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            skip_x_ff      <= skip_x_in;
            skip_y_ff      <= skip_y_in;
            skipped_ff     <= skipped_in;
            bridge_done_ff <= bridge_done_in;
            prev_neg_ff    <= prev_neg_in;
         end
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         ax_ff       <= ax_in;
         ay_ff       <= ay_in;
         bx_ff       <= bx_in;
         by_ff       <= by_in;
         is_point_ff <= is_point_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ax           = ax_ff;
   assign rsp_ay           = ay_ff;
   assign rsp_bx           = bx_ff;
   assign rsp_by           = by_ff;
   assign rsp_is_point     = is_point_ff;
   assign rsp_last_of_item = last_ff;

endmodule

`default_nettype wire

/* rtl/plot_segment_discontinuity_filter.sv */
// Top level of the plot segment discontinuity filter: configuration registers and the two halves.
//
// Each accepted point beat yields zero, one or two result beats (segments, a bridge from
// the saved skip point, or single points), delivered in order with rsp_last_of_item
// marking the final result of a point. The front end takes one point per cycle while the queue
// is not full and spends three pipeline stages on the differences, absolute values and the
// split slope-limit product; a four-entry queue then feeds the back end, which produces one
// result per cycle while rsp_ready is high. The result register is the limit: a point that
// draws a segment plus a bridge holds the queue head until both results are loaded. A point's
// first result passes the three front-end stages, the queue and then the result register.
// Configuration writes take effect at once and are meant to be made while the block is idle.
`default_nettype none

module plot_segment_discontinuity_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [psdf_pkg::COORD_W-1:0] req_px,
   input  wire logic signed [psdf_pkg::COORD_W-1:0] req_py,
   input  wire logic                                req_py_ok,
   input  wire logic                                req_series_start,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [psdf_pkg::COORD_W-1:0]      rsp_ax,
   output logic signed [psdf_pkg::COORD_W-1:0]      rsp_ay,
   output logic signed [psdf_pkg::COORD_W-1:0]      rsp_bx,
   output logic signed [psdf_pkg::COORD_W-1:0]      rsp_by,
   output logic                                     rsp_is_point,
   output logic                                     rsp_last_of_item,
   input  wire logic                                csr_write_enable,
   input  wire logic [psdf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [psdf_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [psdf_pkg::MODE_W-1:0]  plot_mode_ff;
   logic [psdf_pkg::LIMIT_W-1:0] slope_limit_ff;

   psdf_pkg::psdf_push_type  push;
   psdf_pkg::psdf_qstat_type qstat;
   logic                     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         plot_mode_ff   <= psdf_pkg::MODE_CARTESIAN;
         slope_limit_ff <= psdf_pkg::SLOPE_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            psdf_pkg::CSR_PLOT_MODE: begin
               plot_mode_ff <= csr_data[psdf_pkg::MODE_W-1:0];
            end
            psdf_pkg::CSR_SLOPE_LIMIT: begin
               slope_limit_ff <= csr_data[psdf_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   psdf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_px           (req_px),
      .req_py           (req_py),
      .req_py_ok        (req_py_ok),
      .req_series_start (req_series_start),
      .slope_limit      (slope_limit_ff),
      .q_full           (qstat.full),
      .push             (push)
   );

   psdf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .stat  (qstat)
   );

   psdf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .plot_mode        (plot_mode_ff),
      .qstat            (qstat),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ax           (rsp_ax),
      .rsp_ay           (rsp_ay),
      .rsp_bx           (rsp_bx),
      .rsp_by           (rsp_by),
      .rsp_is_point     (rsp_is_point),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

`default_nettype wire
